// ----- hw/rtl/atb_pkg.sv -----
// ----------------------------------------------------------------------------
// atb_pkg: shared types and constants of the taskfile command builder
// register map, request entry layout, opcodes and the opcode picker
// ----------------------------------------------------------------------------
package atb_pkg;

  // field widths fixed by the taskfile layout
  localparam int ATB_ADDR_LO_W   = 32;
  localparam int ATB_ADDR_HI_W   = 16;
  localparam int ATB_TOTAL_W     = 16;
  localparam int ATB_CHS_ADDR_W  = 28;
  localparam int ATB_GEO_W       = 8;
  localparam int ATB_BYTES3_W    = 24;
  localparam int ATB_PADDR_W     = 5;
  localparam int ATB_PDATA_W     = 32;

  // default depth of the queue between front and back
  localparam int ATB_QUEUE_DEPTH = 4;

  // register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_LBA_SUPPORTED     = 3'd0;
  localparam logic [2:0] REG_DMA_ENABLED       = 3'd1;
  localparam logic [2:0] REG_DRIVE_IS_SLAVE    = 3'd2;
  localparam logic [2:0] REG_HEAD_COUNT        = 3'd3;
  localparam logic [2:0] REG_SECTORS_PER_TRACK = 3'd4;

  // device select bits
  localparam logic [7:0] DEVSEL_BASE  = 8'hA0;
  localparam logic [7:0] DEVSEL_LBA   = 8'h40;
  localparam logic [7:0] DEVSEL_SLAVE = 8'h10;

  // command opcodes
  localparam logic [7:0] OP_READ         = 8'h20;
  localparam logic [7:0] OP_READ_48      = 8'h24;
  localparam logic [7:0] OP_READ_DMA     = 8'hC8;
  localparam logic [7:0] OP_READ_DMA_48  = 8'h25;
  localparam logic [7:0] OP_WRITE        = 8'h30;
  localparam logic [7:0] OP_WRITE_48     = 8'h34;
  localparam logic [7:0] OP_WRITE_DMA    = 8'hCA;
  localparam logic [7:0] OP_WRITE_DMA_48 = 8'h35;
  localparam logic [7:0] OP_FLUSH        = 8'hE7;
  localparam logic [7:0] OP_FLUSH_48     = 8'hEA;

  typedef struct packed {
    logic                 lba_supported;
    logic                 dma_enabled;
    logic                 drive_is_slave;
    logic [ATB_GEO_W-1:0] head_count;
    logic [ATB_GEO_W-1:0] sectors_per_track;
  } atb_cfg_t;

  // classified request, as it sits in the queue and travels down the back
  typedef struct packed {
    logic                      is_chs;
    logic [ATB_CHS_ADDR_W-1:0] chs_addr;
    logic                      use_lba48;
    logic [7:0]                count_byte;
    logic [ATB_BYTES3_W-1:0]   addr_low_bytes;
    logic [ATB_BYTES3_W-1:0]   addr_high_bytes;
    logic [7:0]                device_select;
    logic [7:0]                command_byte;
    logic [7:0]                flush_command;
    logic                      geometry_error;
  } atb_req_t;

  function automatic logic [7:0] atb_opcode(input logic wr, input logic big,
                                            input logic dma);
    logic [7:0] op;
    if (wr) begin
      if (dma) op = big ? OP_WRITE_DMA_48 : OP_WRITE_DMA;
      else     op = big ? OP_WRITE_48 : OP_WRITE;
    end else begin
      if (dma) op = big ? OP_READ_DMA_48 : OP_READ_DMA;
      else     op = big ? OP_READ_48 : OP_READ;
    end
    return op;
  endfunction

endpackage

// ----- hw/rtl/atb_regs.sv -----
// ----------------------------------------------------------------------------
// atb_regs: configuration registers
// apb-style write and read of the five drive settings
// ----------------------------------------------------------------------------
module atb_regs
  import atb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ATB_PADDR_W-1:0] paddr,
  input  logic [ATB_PDATA_W-1:0] pwdata,
  output logic [ATB_PDATA_W-1:0] prdata,
  output logic                   pready,
  output atb_cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ATB_PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_LBA_SUPPORTED:     cfg.lba_supported     <= pwdata[0];
        REG_DMA_ENABLED:       cfg.dma_enabled       <= pwdata[0];
        REG_DRIVE_IS_SLAVE:    cfg.drive_is_slave    <= pwdata[0];
        REG_HEAD_COUNT:        cfg.head_count        <= pwdata[ATB_GEO_W-1:0];
        REG_SECTORS_PER_TRACK: cfg.sectors_per_track <= pwdata[ATB_GEO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_LBA_SUPPORTED:     prdata[0] = cfg.lba_supported;
      REG_DMA_ENABLED:       prdata[0] = cfg.dma_enabled;
      REG_DRIVE_IS_SLAVE:    prdata[0] = cfg.drive_is_slave;
      REG_HEAD_COUNT:        prdata[ATB_GEO_W-1:0] = cfg.head_count;
      REG_SECTORS_PER_TRACK: prdata[ATB_GEO_W-1:0] = cfg.sectors_per_track;
      default:               prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/atb_front.sv -----
// ----------------------------------------------------------------------------
// atb_front: request classifier
// picks lba48, lba28 or chs and forms every field that needs no division
// ----------------------------------------------------------------------------
module atb_front
  import atb_pkg::*;
(
  input  atb_cfg_t                 cfg,
  input  logic                     kind,
  input  logic [ATB_ADDR_LO_W-1:0] sector_address,
  input  logic [ATB_ADDR_HI_W-1:0] address_high,
  input  logic [ATB_TOTAL_W-1:0]   sector_total,
  output atb_req_t                 req
);

  logic       big;
  logic       lba28;
  logic       geo_bad;
  logic       issue;
  logic [3:0] head;

  assign big     = (sector_address[ATB_ADDR_LO_W-1:ATB_CHS_ADDR_W] != '0)
                   || (address_high != '0);
  assign lba28   = !big && cfg.lba_supported;
  assign geo_bad = !big && !cfg.lba_supported
                   && (cfg.head_count == '0 || cfg.sectors_per_track == '0);
  assign issue   = !geo_bad;
  // lba28 puts address bits 27:24 into the head field
  assign head    = lba28 ? sector_address[27:24] : 4'd0;

  always_comb begin
    req                 = '0;
    req.is_chs          = !big && !cfg.lba_supported && !geo_bad;
    req.chs_addr        = sector_address[ATB_CHS_ADDR_W-1:0];
    req.use_lba48       = big;
    req.count_byte      = sector_total[7:0];
    req.addr_low_bytes  = (big || lba28) ? sector_address[ATB_BYTES3_W-1:0] : '0;
    req.addr_high_bytes = big ? {address_high, sector_address[31:24]} : '0;
    req.device_select   = DEVSEL_BASE
                          | (cfg.lba_supported ? DEVSEL_LBA : 8'h00)
                          | (cfg.drive_is_slave ? DEVSEL_SLAVE : 8'h00)
                          | {4'h0, head};
    req.command_byte    = issue ? atb_opcode(kind, big, cfg.dma_enabled) : 8'h00;
    req.flush_command   = (issue && kind && !cfg.dma_enabled)
                          ? (big ? OP_FLUSH_48 : OP_FLUSH) : 8'h00;
    req.geometry_error  = geo_bad;
  end

endmodule

// ----- hw/rtl/atb_queue.sv -----
// ----------------------------------------------------------------------------
// atb_queue: request queue
// small fifo between the classifier and the conversion pipeline
// ----------------------------------------------------------------------------
module atb_queue
  import atb_pkg::*;
#(
  parameter int DEPTH = ATB_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  atb_req_t push_data,
  input  logic     pop,
  output atb_req_t head_data,
  output logic     empty,
  output logic     full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  atb_req_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty     = (count == '0);
  assign full      = (count == FULL_CNT);
  assign head_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/atb_div_pipe.sv -----
// ----------------------------------------------------------------------------
// atb_div_pipe: pipelined restoring divider
// one quotient bit per stage, with a valid bit and a tag carried alongside
// ----------------------------------------------------------------------------
module atb_div_pipe
  import atb_pkg::*;
#(
  parameter int NUM_W = ATB_CHS_ADDR_W,
  parameter int DEN_W = ATB_GEO_W,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_in,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             vld_out,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic [TAG_W-1:0] tag_out
);

  logic             vld_q [NUM_W];
  logic [NUM_W-1:0] n_q   [NUM_W];
  logic [DEN_W-1:0] r_q   [NUM_W];
  logic [TAG_W-1:0] tag_q [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic             vld_i;
    logic [NUM_W-1:0] n_i;
    logic [DEN_W-1:0] r_i;
    logic [TAG_W-1:0] tag_i;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign vld_i = vld_in;
      assign n_i   = num;
      assign r_i   = '0;
      assign tag_i = tag_in;
    end else begin : g_next
      assign vld_i = vld_q[s-1];
      assign n_i   = n_q[s-1];
      assign r_i   = r_q[s-1];
      assign tag_i = tag_q[s-1];
    end

    // shift in the next dividend bit, subtract the divisor if it fits
    assign trial = {r_i, n_i[NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[s]   <= {n_i[NUM_W-2:0], ge};
        r_q[s]   <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        tag_q[s] <= tag_i;
      end
    end
  end

  assign vld_out = vld_q[NUM_W-1];
  assign quo     = n_q[NUM_W-1];
  assign rem     = r_q[NUM_W-1];
  assign tag_out = tag_q[NUM_W-1];

endmodule

// ----- hw/rtl/atb_back.sv -----
// ----------------------------------------------------------------------------
// atb_back: chs conversion and result register
// two chained dividers then the output stage; the whole pipe holds on a stall
// ----------------------------------------------------------------------------
module atb_back
  import atb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  atb_cfg_t                cfg,
  input  logic                    q_empty,
  input  atb_req_t                q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    use_lba48,
  output logic [7:0]              count_byte,
  output logic [ATB_BYTES3_W-1:0] addr_low_bytes,
  output logic [ATB_BYTES3_W-1:0] addr_high_bytes,
  output logic [7:0]              device_select,
  output logic [7:0]              command_byte,
  output logic [7:0]              flush_command,
  output logic                    geometry_error
);

  localparam int REQ_W = $bits(atb_req_t);

  logic                      en;
  logic                      v1;
  logic [ATB_CHS_ADDR_W-1:0] q1;
  logic [ATB_GEO_W-1:0]      r1;
  logic [REQ_W-1:0]          t1;
  logic                      v2;
  logic [ATB_CHS_ADDR_W-1:0] q2;
  logic [ATB_GEO_W-1:0]      r2;
  logic [REQ_W-1:0]          t2_req;
  logic [ATB_GEO_W-1:0]      t2_rem;
  atb_req_t                  req1;
  atb_req_t                  done;
  logic [ATB_GEO_W-1:0]      sect;

  // the pipe moves whenever the output slot is free or being taken
  assign en    = !out_valid || !out_stall;
  assign q_pop = en && !q_empty;

  // track = addr / spt, sector index = addr mod spt
  atb_div_pipe #(
    .NUM_W (ATB_CHS_ADDR_W),
    .DEN_W (ATB_GEO_W),
    .TAG_W (REQ_W)
  ) u_div_track (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (q_pop),
    .num     (q_head.chs_addr),
    .den     (cfg.sectors_per_track),
    .tag_in  (q_head),
    .vld_out (v1),
    .quo     (q1),
    .rem     (r1),
    .tag_out (t1)
  );

  // cylinder = track / heads, head = track mod heads
  atb_div_pipe #(
    .NUM_W (ATB_CHS_ADDR_W),
    .DEN_W (ATB_GEO_W),
    .TAG_W (REQ_W + ATB_GEO_W)
  ) u_div_cyl (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (v1),
    .num     (q1),
    .den     (cfg.head_count),
    .tag_in  ({t1, r1}),
    .vld_out (v2),
    .quo     (q2),
    .rem     (r2),
    .tag_out ({t2_req, t2_rem})
  );

  assign req1 = atb_req_t'(t2_req);
  assign sect = t2_rem + 1'b1;

  always_comb begin
    done = req1;
    if (req1.is_chs) begin
      done.addr_low_bytes = {q2[15:0], sect};
      done.device_select  = req1.device_select | {4'h0, r2[3:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      use_lba48       <= done.use_lba48;
      count_byte      <= done.count_byte;
      addr_low_bytes  <= done.addr_low_bytes;
      addr_high_bytes <= done.addr_high_bytes;
      device_select   <= done.device_select;
      command_byte    <= done.command_byte;
      flush_command   <= done.flush_command;
      geometry_error  <= done.geometry_error;
    end
  end

endmodule

// ----- hw/rtl/ata_taskfile_command_builder_unit.sv -----
// ----------------------------------------------------------------------------
// ata_taskfile_command_builder_unit: ata taskfile command builder
// turns a sector read or write request into taskfile register values
// ----------------------------------------------------------------------------
//
//   port group   dir  handshake          carries
//   ----------   ---  -----------------  -----------------------------------
//   apb          in   psel/penable       five drive settings, read back
//   request      in   in_valid/in_stall  kind, address, sector total
//   result       out  out_valid/stall    taskfile bytes, flush, error flag
//
// one request is taken per cycle while the queue is not full, and one result
// leaves per cycle while out_stall is low. an accepted request passes the
// queue, then the track divider (its first stage loads straight from the queue
// head), the cylinder divider (one quotient bit per stage) and the result register.
// rst is synchronous; it clears the settings, queue and pipeline valid bits.
// a stalled result holds the whole back pipeline; the queue keeps taking
// requests until it is full, and in_stall is the queue's full flag.
//
module ata_taskfile_command_builder_unit
  import atb_pkg::*;
#(
  parameter int QUEUE_DEPTH = ATB_QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ATB_PADDR_W-1:0]   paddr,
  input  logic [ATB_PDATA_W-1:0]   pwdata,
  output logic [ATB_PDATA_W-1:0]   prdata,
  output logic                     pready,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic [ATB_ADDR_LO_W-1:0] sector_address,
  input  logic [ATB_ADDR_HI_W-1:0] address_high,
  input  logic [ATB_TOTAL_W-1:0]   sector_total,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     use_lba48,
  output logic [7:0]               count_byte,
  output logic [ATB_BYTES3_W-1:0]  addr_low_bytes,
  output logic [ATB_BYTES3_W-1:0]  addr_high_bytes,
  output logic [7:0]               device_select,
  output logic [7:0]               command_byte,
  output logic [7:0]               flush_command,
  output logic                     geometry_error
);

  atb_cfg_t cfg;
  atb_req_t front_req;
  atb_req_t q_head;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  logic     push;

  // the user must change settings only while no request is in flight; the block does not enforce it
  atb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // classify the request: lba48, lba28, chs or bad geometry
  atb_front u_front (
    .cfg            (cfg),
    .kind           (kind),
    .sector_address (sector_address),
    .address_high   (address_high),
    .sector_total   (sector_total),
    .req            (front_req)
  );

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  atb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_req),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // every request runs through the dividers; only chs ones use the result
  atb_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .use_lba48       (use_lba48),
    .count_byte      (count_byte),
    .addr_low_bytes  (addr_low_bytes),
    .addr_high_bytes (addr_high_bytes),
    .device_select   (device_select),
    .command_byte    (command_byte),
    .flush_command   (flush_command),
    .geometry_error  (geometry_error)
  );

endmodule
